/* rtl/ppi_pkg.sv */
// Package for the particle pool integrator: types, constants and helpers.
package ppi_pkg;

   localparam int DEFAULT_POOL_SLOTS = 256;
   localparam logic [31:0] GRAVITY_RESET = 32'd642908;

   localparam logic [1:0] OP_EMIT = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [23:0]      color;
      logic [23:0]      life;
      logic [23:0]      age;
   } slot_rec_type;

   typedef struct packed {
      logic load_req;
      logic idx_clr;
      logic idx_inc;
      logic gdt_load;
      logic rd_slot;
      logic rd_user;
      logic vel_calc;
      logic mul_calc;
      logic tick_wb;
      logic emit_wr;
      logic set_full;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic slot_alive;
      logic idx_last;
      logic rsp_busy;
   } stat_type;

   // clamp a 42-bit signed value to the signed 32-bit range
   function automatic logic [31:0] sat_s32(input logic [41:0] x);
      logic [31:0] r;
      if (x[41:31] == 11'h000 || x[41:31] == 11'h7FF) begin
         r = x[31:0];
      end else if (x[41]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

/* rtl/ppi_req_if.sv */
// Request channel of the particle pool integrator.
interface ppi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   logic [31:0] vel_x;
   logic [31:0] vel_y;
   logic [31:0] vel_z;
   logic [23:0] color_rgb;
   logic [23:0] life_span;
   logic [23:0] time_step;
   logic [7:0]  read_index;

   modport source (output valid, operation, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   color_rgb, life_span, time_step, read_index, input ready);
   modport sink (input valid, operation, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 color_rgb, life_span, time_step, read_index, output ready);
endinterface

/* rtl/ppi_rsp_if.sv */
// Response channel of the particle pool integrator.
interface ppi_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [7:0]  slot_used;
   logic        slot_alive;
   logic [31:0] out_pos_x;
   logic [31:0] out_pos_y;
   logic [31:0] out_pos_z;
   logic [31:0] out_vel_x;
   logic [31:0] out_vel_y;
   logic [31:0] out_vel_z;
   logic [23:0] out_color;
   logic [23:0] out_age;
   logic [8:0]  alive_total;

   modport source (output valid, status, slot_used, slot_alive, out_pos_x, out_pos_y,
                   out_pos_z, out_vel_x, out_vel_y, out_vel_z, out_color, out_age,
                   alive_total, input ready);
   modport sink (input valid, status, slot_used, slot_alive, out_pos_x, out_pos_y,
                 out_pos_z, out_vel_x, out_vel_y, out_vel_z, out_color, out_age,
                 alive_total, output ready);
endinterface

/* rtl/particle_pool_integrator.sv */
// Top level of the particle pool integrator.
// The block keeps POOL_SLOTS particle slots in one slot memory (position,
// velocity, color, lifetime, age) with an alive bit per slot in flip-flops
// and a running alive count. One request is worked on at a time; the request
// channel is ready only while the controller is idle, and the response
// register lets the next request in while a result still waits. An emit scans
// up from slot 0 for the lowest dead slot, testing one alive bit per cycle; a
// read does one registered memory read; a tick walks every slot, skipping dead
// ones and taking each alive slot through the read, velocity update, multiply
// and write-back steps, which share the slot memory and one set of multipliers.
// An emit with every slot alive is dropped and flagged in status. Gravity
// (signed Q16.16) is written through csr_write_enable / csr_write_data; the user
// must write it only while the block is idle, which the block does not enforce.
// The slot memory needs no clearing pass after reset.
module particle_pool_integrator #(
   parameter int POOL_SLOTS = ppi_pkg::DEFAULT_POOL_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   ppi_req_if.sink     req_chan,
   ppi_rsp_if.source   rsp_chan
);
   import ppi_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence the work
   ppi_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .stat          (stat),
      .cmd           (cmd)
   );

   // hold the slots and do the arithmetic
   ppi_datapath #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

endmodule

/* rtl/ppi_datapath.sv */
// Datapath: slot memory, alive map, integrator arithmetic and response register.
module ppi_datapath #(
   parameter int POOL_SLOTS = ppi_pkg::DEFAULT_POOL_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  ppi_pkg::cmd_type  cmd,
   output ppi_pkg::stat_type stat,
   input  logic              csr_write_enable,
   input  logic [31:0]       csr_write_data,
   ppi_req_if.sink           req_chan,
   ppi_rsp_if.source         rsp_chan
);
   import ppi_pkg::*;

   localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int CNT_W = $clog2(POOL_SLOTS + 1);

   logic [31:0]       gravity_ff;
   logic [1:0]        op_ff;
   slot_rec_type      req_rec_ff;
   logic [23:0]       dt_ff;
   logic [7:0]        rindex_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [POOL_SLOTS-1:0] alive_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              full_ff;
   logic [56:0]       gdt_ff;
   slot_rec_type      rd_ff;
   logic [31:0]       vely_ff;
   logic [2:0][56:0]  prod_ff;
   slot_rec_type      mem [POOL_SLOTS];

   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  user_idx;
   logic              user_in_range;
   logic              user_alive;
   slot_rec_type      wb_rec;
   slot_rec_type      wr_rec;
   logic [24:0]       age_sum;
   logic [23:0]       age_new;
   logic              kill;
   logic [40:0]       gstep;
   logic [2:0][40:0]  pstep;
   logic              rsp_valid_ff;
   logic              rsp_status_in;
   logic [7:0]        rsp_slot_in;
   logic              rsp_alive_in;
   slot_rec_type      rsp_rec_in;

   assign user_idx      = IDX_W'(rindex_ff);
   assign user_in_range = 32'(rindex_ff) < POOL_SLOTS;
   assign user_alive    = user_in_range && alive_ff[user_idx];
   assign rd_addr       = cmd.rd_user ? user_idx : idx_ff;

   assign req_chan.ready = 1'b0 | cmd.load_req;

   assign stat.slot_alive = alive_ff[idx_ff];
   assign stat.idx_last   = idx_ff == IDX_W'(POOL_SLOTS - 1);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_chan.ready;

   // tick arithmetic
   assign gstep   = gdt_ff[56:16];
   assign age_sum = {1'b0, rd_ff.age} + {1'b0, dt_ff};
   assign age_new = age_sum[24] ? 24'hFF_FFFF : age_sum[23:0];
   assign kill    = age_new >= rd_ff.life;

   always_comb begin
      wb_rec = rd_ff;
      wb_rec.vel[1] = vely_ff;
      for (int c = 0; c < 3; c++) begin
         pstep[c] = prod_ff[c][56:16];
         wb_rec.pos[c] = sat_s32({{10{rd_ff.pos[c][31]}}, rd_ff.pos[c]}
                                 + {pstep[c][40], pstep[c]});
      end
      wb_rec.age = age_new;
      wr_rec = cmd.emit_wr ? req_rec_ff : wb_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= GRAVITY_RESET;
         alive_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            gravity_ff <= csr_write_data;
         end
         if (cmd.emit_wr) begin
            alive_ff[idx_ff] <= 1'b1;
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.tick_wb && kill) begin
            alive_ff[idx_ff] <= 1'b0;
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff          <= req_chan.operation;
         req_rec_ff.pos <= {req_chan.pos_z, req_chan.pos_y, req_chan.pos_x};
         req_rec_ff.vel <= {req_chan.vel_z, req_chan.vel_y, req_chan.vel_x};
         req_rec_ff.color <= req_chan.color_rgb;
         req_rec_ff.life  <= req_chan.life_span;
         req_rec_ff.age   <= '0;
         dt_ff     <= req_chan.time_step;
         rindex_ff <= req_chan.read_index;
         full_ff   <= 1'b0;
      end else if (cmd.set_full) begin
         full_ff <= 1'b1;
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.gdt_load) begin
         gdt_ff <= 57'($signed(gravity_ff) * $signed({1'b0, dt_ff}));
      end
      if (cmd.vel_calc) begin
         vely_ff <= sat_s32({{10{rd_ff.vel[1][31]}}, rd_ff.vel[1]}
                            - {gstep[40], gstep});
      end
      if (cmd.mul_calc) begin
         prod_ff[0] <= 57'($signed(rd_ff.vel[0]) * $signed({1'b0, dt_ff}));
         prod_ff[1] <= 57'($signed(vely_ff) * $signed({1'b0, dt_ff}));
         prod_ff[2] <= 57'($signed(rd_ff.vel[2]) * $signed({1'b0, dt_ff}));
      end
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.emit_wr || cmd.tick_wb) begin
         mem[idx_ff] <= wr_rec;
      end
      if (cmd.rd_slot || cmd.rd_user) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // response fields: zero unless the operation fills them
   always_comb begin
      rsp_status_in = 1'b0;
      rsp_slot_in   = '0;
      rsp_alive_in  = 1'b0;
      rsp_rec_in    = '0;
      if (op_ff == OP_EMIT) begin
         rsp_status_in = full_ff;
         rsp_slot_in   = full_ff ? 8'd0 : 8'(idx_ff);
      end else if (op_ff == OP_READ) begin
         rsp_slot_in = rindex_ff;
         if (user_alive) begin
            rsp_alive_in = 1'b1;
            rsp_rec_in   = rd_ff;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_chan.status      <= rsp_status_in;
         rsp_chan.slot_used   <= rsp_slot_in;
         rsp_chan.slot_alive  <= rsp_alive_in;
         rsp_chan.out_pos_x   <= rsp_rec_in.pos[0];
         rsp_chan.out_pos_y   <= rsp_rec_in.pos[1];
         rsp_chan.out_pos_z   <= rsp_rec_in.pos[2];
         rsp_chan.out_vel_x   <= rsp_rec_in.vel[0];
         rsp_chan.out_vel_y   <= rsp_rec_in.vel[1];
         rsp_chan.out_vel_z   <= rsp_rec_in.vel[2];
         rsp_chan.out_color   <= rsp_rec_in.color;
         rsp_chan.out_age     <= rsp_rec_in.age;
         rsp_chan.alive_total <= 9'(count_ff);
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

/* rtl/ppi_controller.sv */
// Controller: sequences emit scans, tick walks, slot reads and responses.
module ppi_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_operation,
   input  ppi_pkg::stat_type stat,
   output ppi_pkg::cmd_type  cmd
);
   import ppi_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_EMIT = 4'd1;
   localparam logic [3:0] S_GDT  = 4'd2;
   localparam logic [3:0] S_SCAN = 4'd3;
   localparam logic [3:0] S_VEL  = 4'd4;
   localparam logic [3:0] S_MUL  = 4'd5;
   localparam logic [3:0] S_WB   = 4'd6;
   localparam logic [3:0] S_READ = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_req = 1'b1;
            cmd.idx_clr  = 1'b1;
            if (req_valid) begin
               unique case (req_operation)
                  OP_EMIT: state_in = S_EMIT;
                  OP_TICK: state_in = S_GDT;
                  OP_READ: state_in = S_READ;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_EMIT: begin
            if (!stat.slot_alive) begin
               cmd.emit_wr = 1'b1;
               state_in    = S_DONE;
            end else if (stat.idx_last) begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_GDT: begin
            cmd.gdt_load = 1'b1;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            if (stat.slot_alive) begin
               cmd.rd_slot = 1'b1;
               state_in    = S_VEL;
            end else if (stat.idx_last) begin
               state_in = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_VEL: begin
            cmd.vel_calc = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_calc = 1'b1;
            state_in     = S_WB;
         end
         S_WB: begin
            cmd.tick_wb = 1'b1;
            if (stat.idx_last) begin
               state_in = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_READ: begin
            cmd.rd_user = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // hold until the previous response is taken
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/ppi_checker.sv */
// Port-level checker for the particle pool integrator, with its bind.
module ppi_checker #(
   parameter int POOL_SLOTS = ppi_pkg::DEFAULT_POOL_SLOTS
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_status,
   input logic [7:0] rsp_slot_used,
   input logic       rsp_slot_alive,
   input logic [8:0] rsp_alive_total
);
   localparam logic [8:0] FULL_TOTAL = 9'(POOL_SLOTS);

   // no response straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alive_total))
      else $error("stalled response changed");

   // a dropped emit means a full pool and no slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_alive_total == FULL_TOTAL && rsp_slot_used == 8'd0
         && !rsp_slot_alive)
      else $error("drop flagged without full pool");

   // a live slot read implies at least one alive slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_alive |-> rsp_alive_total != 9'd0 || FULL_TOTAL == 9'd0)
      else $error("alive slot with zero alive count");

endmodule

bind particle_pool_integrator ppi_checker #(.POOL_SLOTS(POOL_SLOTS)) u_ppi_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_slot_used   (rsp_chan.slot_used),
   .rsp_slot_alive  (rsp_chan.slot_alive),
   .rsp_alive_total (rsp_chan.alive_total)
);
